FILE: rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table for the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

   // Angle word of the rotation unit (Q30 radians) and its vector word.
   typedef logic signed [36:0] angle_type;
   typedef logic signed [33:0] vec_type;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int IDX_W            = 5;

   localparam logic signed [20:0] TWO_PI_Q16   = 21'sd411775;
   localparam angle_type          PI_Q30       = 37'sd3373259426;
   localparam angle_type          TWO_PI_Q30   = 37'sd6746518852;
   localparam angle_type          HALF_PI_Q30  = 37'sd1686629713;
   localparam vec_type            GAIN_Q30     = 34'sd652032874;

   localparam logic [23:0] DPT_RESET = 24'd669133;
   localparam logic [15:0] INV_RESET = 16'd4681;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_DIST_PER_TURN = 8'd0;
   localparam logic [7:0] CSR_INVERSE_TRACK = 8'd1;

   // Arctangent of 2^-i in Q30, truncated.
   function automatic angle_type atan_q30(input logic [IDX_W-1:0] idx);
      angle_type val;
      case (idx)
         5'd0:  val = 37'sd843314856;
         5'd1:  val = 37'sd497837829;
         5'd2:  val = 37'sd263043836;
         5'd3:  val = 37'sd133525158;
         5'd4:  val = 37'sd67021686;
         5'd5:  val = 37'sd33543515;
         5'd6:  val = 37'sd16775850;
         5'd7:  val = 37'sd8388437;
         5'd8:  val = 37'sd4194282;
         5'd9:  val = 37'sd2097149;
         5'd10: val = 37'sd1048575;
         5'd11: val = 37'sd524287;
         5'd12: val = 37'sd262143;
         5'd13: val = 37'sd131071;
         5'd14: val = 37'sd65535;
         5'd15: val = 37'sd32767;
         5'd16: val = 37'sd16383;
         5'd17: val = 37'sd8191;
         5'd18: val = 37'sd4095;
         5'd19: val = 37'sd2047;
         5'd20: val = 37'sd1023;
         5'd21: val = 37'sd511;
         5'd22: val = 37'sd255;
         5'd23: val = 37'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on a shared
// add/shift datapath, giving sine and cosine in Q30 of an angle in +-pi/2.
// ----------------------------------------------------------------------------
module ddo_cordic
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   input  angle_type  angle,
   output logic       done,
   output vec_type    sin_out,
   output vec_type    cos_out
);

   localparam int STEP_COUNT = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   vec_type          x_ff, x_in, y_ff, y_in;
   angle_type        z_ff, z_in;
   vec_type          x_sh, y_sh;

   assign x_sh = x_ff >>> idx_ff;
   assign y_sh = y_ff >>> idx_ff;

   // Sequencing of the micro-rotations.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = angle;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_q30(idx_ff);
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_q30(idx_ff);
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IDX_W'(STEP_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = done_ff;
   assign sin_out = y_ff;
   assign cos_out = x_ff;

endmodule
`default_nettype wire

FILE: rtl/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The time from the accepted request beat to the response beat is set by the
// CORDIC iterations and by the eight products on the one shared multiplier.
// The core takes one item at a time; the request side is not ready while an
// item is in progress. Reset is synchronous and clears pose, heading, last
// positions and restores the default configuration.
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry: encoder deltas, wheel distances, heading change, and the
// projection of travel through the mid-step heading into saturating x and y.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire signed [31:0]  req_left_position,
   input  wire signed [31:0]  req_right_position,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic signed [19:0] rsp_heading,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire        [7:0]   csr_index,
   input  wire        [23:0]  csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ML    = 4'd1;
   localparam logic [3:0] ST_MR    = 4'd2;
   localparam logic [3:0] ST_DIFF  = 4'd3;
   localparam logic [3:0] ST_MDH   = 4'd4;
   localparam logic [3:0] ST_MDL   = 4'd5;
   localparam logic [3:0] ST_THETA = 4'd6;
   localparam logic [3:0] ST_PREP  = 4'd7;
   localparam logic [3:0] ST_CORD  = 4'd8;
   localparam logic [3:0] ST_SHI   = 4'd9;
   localparam logic [3:0] ST_SLO   = 4'd10;
   localparam logic [3:0] ST_CHI   = 4'd11;
   localparam logic [3:0] ST_CLO   = 4'd12;
   localparam logic [3:0] ST_UPD   = 4'd13;

   localparam logic signed [45:0] DIST_HI = 46'sd4294967295;
   localparam logic signed [45:0] DIST_LO = -46'sd4294967295;
   localparam logic signed [47:0] TH_HI   = 48'sd411775;
   localparam logic signed [47:0] TH_LO   = -48'sd411775;
   localparam logic signed [36:0] X_MAX   = 37'sd2147483647;
   localparam logic signed [36:0] X_MIN   = -37'sd2147483648;

   logic [3:0]         state_ff, state_in;
   logic [23:0]        dpt_ff, dpt_in;
   logic [15:0]        inv_ff, inv_in;
   logic [31:0]        last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in;
   logic signed [44:0] ldist_ff, ldist_in, rdist_ff, rdist_in;
   logic signed [45:0] diff_ff, diff_in;
   logic signed [32:0] dist_ff, dist_in;
   logic signed [46:0] thi_ff, thi_in;
   logic [16:0]        tlo_ff, tlo_in;
   logic signed [19:0] dtheta_ff, dtheta_in;
   logic               neg_ff, neg_in;
   vec_type            s_ff, s_in, c_ff, c_in;
   logic signed [59:0] phi_ff, phi_in;
   logic signed [35:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [19:0] acc_h_ff, acc_h_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [19:0] rsp_h_ff, rsp_h_in;

   logic signed [34:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [59:0] prod;

   logic               cord_start, cord_done;
   angle_type          cord_angle;
   vec_type            cord_sin, cord_cos;

   logic signed [45:0] sum_lr, half_lr;
   logic signed [47:0] th_sum;
   logic signed [20:0] mid;
   angle_type          z0, z1, z2;
   logic               fold;
   logic signed [65:0] proj_sum;
   logic signed [36:0] nx, ny;
   logic signed [20:0] th_new;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ML: begin
            mul_a = 35'(dl_ff);
            mul_b = $signed({1'b0, dpt_ff});
         end
         ST_MR: begin
            mul_a = 35'(dr_ff);
            mul_b = $signed({1'b0, dpt_ff});
         end
         ST_MDH: begin
            mul_a = 35'($signed(diff_ff[45:16]));
            mul_b = $signed({9'd0, inv_ff});
         end
         ST_MDL: begin
            mul_a = $signed({19'd0, diff_ff[15:0]});
            mul_b = $signed({9'd0, inv_ff});
         end
         ST_SHI: begin
            mul_a = 35'(s_ff);
            mul_b = 25'($signed(dist_ff[32:16]));
         end
         ST_SLO: begin
            mul_a = 35'(s_ff);
            mul_b = $signed({9'd0, dist_ff[15:0]});
         end
         ST_CHI: begin
            mul_a = 35'(c_ff);
            mul_b = 25'($signed(dist_ff[32:16]));
         end
         ST_CLO: begin
            mul_a = 35'(c_ff);
            mul_b = $signed({9'd0, dist_ff[15:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = 60'(mul_a * mul_b);

   // Mean distance, heading change and the reduction of the mid-step angle.
   assign sum_lr  = 46'(ldist_ff) + 46'(rdist_ff);
   assign half_lr = sum_lr >>> 1;
   assign th_sum  = 48'(thi_ff) + $signed({31'd0, tlo_ff});
   assign mid     = 21'(acc_h_ff) + 21'(dtheta_ff >>> 1);
   assign z0      = 37'(mid) <<< 14;
   always_comb begin
      z1 = z0;
      if (z1 > PI_Q30) z1 = z1 - TWO_PI_Q30;
      if (z1 < -PI_Q30) z1 = z1 + TWO_PI_Q30;
      fold = 1'b0;
      z2   = z1;
      if (z1 > HALF_PI_Q30) begin
         z2   = z1 - PI_Q30;
         fold = 1'b1;
      end else if (z1 < -HALF_PI_Q30) begin
         z2   = z1 + PI_Q30;
         fold = 1'b1;
      end
   end

   assign cord_start = (state_ff == ST_PREP);
   assign cord_angle = z2;

   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .done    (cord_done),
      .sin_out (cord_sin),
      .cos_out (cord_cos)
   );

   // Projection: high partial product shifted up plus the low one, floor by 2^30.
   assign proj_sum = (66'(phi_ff) <<< 16) + 66'(prod);
   assign nx       = 37'(acc_x_ff) + 37'(px_ff);
   assign ny       = 37'(acc_y_ff) + 37'(py_ff);
   assign th_new   = 21'(acc_h_ff) + 21'(dtheta_ff);

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      dpt_in       = dpt_ff;
      inv_in       = inv_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      ldist_in     = ldist_ff;
      rdist_in     = rdist_ff;
      diff_in      = diff_ff;
      dist_in      = dist_ff;
      thi_in       = thi_ff;
      tlo_in       = tlo_ff;
      dtheta_in    = dtheta_ff;
      neg_in       = neg_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      phi_in       = phi_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_h_in     = acc_h_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         if (csr_index == CSR_DIST_PER_TURN) dpt_in = csr_data;
         else if (csr_index == CSR_INVERSE_TRACK) inv_in = csr_data[15:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dl_in     = $signed(req_left_position - last_l_ff);
               dr_in     = $signed(req_right_position - last_r_ff);
               last_l_in = req_left_position;
               last_r_in = req_right_position;
               state_in  = ST_ML;
            end
         end
         ST_ML: begin
            ldist_in = 45'(prod >>> 12);
            state_in = ST_MR;
         end
         ST_MR: begin
            rdist_in = 45'(prod >>> 12);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in = 46'(ldist_ff) - 46'(rdist_ff);
            if (half_lr > DIST_HI) dist_in = 33'(DIST_HI);
            else if (half_lr < DIST_LO) dist_in = 33'(DIST_LO);
            else dist_in = 33'(half_lr);
            state_in = ST_MDH;
         end
         ST_MDH: begin
            thi_in   = 47'(prod);
            state_in = ST_MDL;
         end
         ST_MDL: begin
            tlo_in   = prod[32:16];
            state_in = ST_THETA;
         end
         ST_THETA: begin
            if (th_sum > TH_HI) dtheta_in = 20'(TH_HI);
            else if (th_sum < TH_LO) dtheta_in = 20'(TH_LO);
            else dtheta_in = 20'(th_sum);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            neg_in   = fold;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cord_done) begin
               s_in     = neg_ff ? -cord_sin : cord_sin;
               c_in     = neg_ff ? -cord_cos : cord_cos;
               state_in = ST_SHI;
            end
         end
         ST_SHI: begin
            phi_in   = prod;
            state_in = ST_SLO;
         end
         ST_SLO: begin
            px_in    = proj_sum[65:30];
            state_in = ST_CHI;
         end
         ST_CHI: begin
            phi_in   = prod;
            state_in = ST_CLO;
         end
         ST_CLO: begin
            py_in    = proj_sum[65:30];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (nx > X_MAX) acc_x_in = 32'(X_MAX);
               else if (nx < X_MIN) acc_x_in = 32'(X_MIN);
               else acc_x_in = 32'(nx);
               if (ny > X_MAX) acc_y_in = 32'(X_MAX);
               else if (ny < X_MIN) acc_y_in = 32'(X_MIN);
               else acc_y_in = 32'(ny);
               if (th_new > TWO_PI_Q16) acc_h_in = 20'(th_new - TWO_PI_Q16);
               else if (th_new < -TWO_PI_Q16) acc_h_in = 20'(th_new + TWO_PI_Q16);
               else acc_h_in = 20'(th_new);
               rsp_x_in     = acc_x_in;
               rsp_y_in     = acc_y_in;
               rsp_h_in     = acc_h_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dpt_ff       <= DPT_RESET;
         inv_ff       <= INV_RESET;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_h_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dpt_ff       <= dpt_in;
         inv_ff       <= inv_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_h_ff     <= acc_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      ldist_ff  <= ldist_in;
      rdist_ff  <= rdist_in;
      diff_ff   <= diff_in;
      dist_ff   <= dist_in;
      thi_ff    <= thi_in;
      tlo_ff    <= tlo_in;
      dtheta_ff <= dtheta_in;
      neg_ff    <= neg_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      phi_ff    <= phi_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_h_ff  <= rsp_h_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pose_x  = rsp_x_ff;
   assign rsp_pose_y  = rsp_y_ff;
   assign rsp_heading = rsp_h_ff;

endmodule
`default_nettype wire
